[rtl/core/b64d_pkg.sv]
// b64d_pkg: shared types, constants and the character classifier of the
// Base64 stream decoder. No dependencies.
package b64d_pkg;

   localparam logic [7:0] PAD_CHAR   = 8'd61;
   localparam logic [5:0] MASK_HI2   = 6'h30;
   localparam logic [5:0] MASK_HI4   = 6'h3C;
   localparam logic [5:0] MASK_LO4   = 6'h0F;
   localparam logic [5:0] MASK_LO2   = 6'h03;

   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;
   localparam logic [1:0] PHASE_FOURTH = 2'd3;

   // One classified character as it travels from the front to the back.
   typedef struct packed {
      logic [5:0] sextet;
      logic       is_sextet;
      logic       is_pad;
      logic       last;
   } class_type;

   function automatic class_type classify(input logic [7:0] c, input logic last);
      class_type  r;
      logic [7:0] d;
      r.sextet    = '0;
      r.is_sextet = 1'b0;
      r.is_pad    = (c == PAD_CHAR);
      r.last      = last;
      d           = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         d           = c - 8'h41;
         r.sextet    = d[5:0];
         r.is_sextet = 1'b1;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d           = c - 8'h61 + 8'd26;
         r.sextet    = d[5:0];
         r.is_sextet = 1'b1;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         d           = c - 8'h30 + 8'd52;
         r.sextet    = d[5:0];
         r.is_sextet = 1'b1;
      end else if (c == 8'h2B) begin
         r.sextet    = 6'd62;
         r.is_sextet = 1'b1;
      end else if (c == 8'h2F) begin
         r.sextet    = 6'd63;
         r.is_sextet = 1'b1;
      end
      return r;
   endfunction

endpackage

[rtl/core/base64_stream_decoder_unit.sv]
// base64_stream_decoder_unit: top level of the Base64 stream decoder.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
//  channel | direction | tdata              | tuser                     | tlast
//  req_    | in        | [7:0] char_in      | -                         | last_char
//  rsp_    | out       | [7:0] data_byte    | [0] byte_valid [1] pad_seen | message_end
//
// One result transaction per input transaction, in order.
// Throughput: one character per cycle while rsp_ is not stalled; a character
// is registered in the queue, then in the back's result register, before rsp_tvalid.
// Reset (synchronous, active high) empties the queue and result register and
// clears group position, held sextet and stopped flag.
// A stalled rsp_ side holds the result; the two-entry queue absorbs input
// until full, then req_tready drops.
module base64_stream_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic [1:0] rsp_tuser,   // [0] byte_valid, [1] pad_seen
   output logic       rsp_tlast
);
   import b64d_pkg::*;

   // Classified characters from the front into the queue.
   logic      push_valid, push_ready;
   class_type push_item;
   // Queue head towards the back.
   logic      pop_valid, pop_ready;
   class_type pop_item;

   // Front: accept and classify each character.
   b64d_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // Queue: decouple front stalls from back stalls.
   b64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Back: advance the group state and register the result.
   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[rtl/core/b64d_front.sv]
// b64d_front: accepts input characters and classifies them for the queue.
// Depends on b64d_pkg.
module b64d_front (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   output logic                  push_valid,
   input  logic                  push_ready,
   output b64d_pkg::class_type   push_item
);
   import b64d_pkg::*;

   // Map the character to a sextet, pad mark or skip.
   assign push_item  = classify(req_tdata, req_tlast);
   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

[rtl/core/b64d_queue.sv]
// b64d_queue: two-entry queue of classified characters between front and back.
// Depends on b64d_pkg.
module b64d_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  b64d_pkg::class_type   push_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output b64d_pkg::class_type   pop_item
);
   import b64d_pkg::*;

   class_type  entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_pointers_match_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

[rtl/core/b64d_back.sv]
// b64d_back: applies classified characters to the group state and holds the
// result register. Depends on b64d_pkg.
module b64d_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  b64d_pkg::class_type   pop_item,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);
   import b64d_pkg::*;

   logic [1:0] phase_ff,   phase_in;
   logic [5:0] held_ff,    held_in;
   logic       stopped_ff, stopped_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_bvalid_ff, out_bvalid_in;
   logic       out_pad_ff, out_pad_in;
   logic       out_last_ff, out_last_in;
   logic       pop;
   logic [5:0] s;

   assign pop_ready = !out_valid_ff || rsp_tready;
   assign pop       = pop_valid && pop_ready;
   assign s         = pop_item.sextet;

   always_comb begin
      phase_in      = phase_ff;
      held_in       = held_ff;
      stopped_in    = stopped_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_byte_in   = out_byte_ff;
      out_bvalid_in = out_bvalid_ff;
      out_pad_in    = out_pad_ff;
      out_last_in   = out_last_ff;
      if (pop) begin
         out_valid_in  = 1'b1;
         out_byte_in   = '0;
         out_bvalid_in = 1'b0;
         if (!stopped_ff) begin
            if (pop_item.is_pad && phase_ff[1]) begin
               stopped_in = 1'b1;
            end else if (pop_item.is_sextet) begin
               unique case (phase_ff)
                  PHASE_FIRST: begin
                     out_bvalid_in = 1'b0;
                  end
                  PHASE_SECOND: begin
                     out_byte_in   = {held_ff, 2'(((s & MASK_HI2) >> 4))};
                     out_bvalid_in = 1'b1;
                  end
                  PHASE_THIRD: begin
                     out_byte_in   = {4'(held_ff & MASK_LO4), 4'(((s & MASK_HI4) >> 2))};
                     out_bvalid_in = 1'b1;
                  end
                  PHASE_FOURTH: begin
                     out_byte_in   = {2'(held_ff & MASK_LO2), s};
                     out_bvalid_in = 1'b1;
                  end
                  default: begin
                     out_bvalid_in = 1'b0;
                  end
               endcase
               held_in  = s;
               phase_in = phase_ff + 2'd1;
            end
         end
         out_pad_in  = stopped_in;
         out_last_in = pop_item.last;
         // End of message: drop leftover bits and resume decoding.
         if (pop_item.last) begin
            phase_in   = PHASE_FIRST;
            held_in    = '0;
            stopped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_FIRST;
         held_ff      <= '0;
         stopped_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         stopped_ff   <= stopped_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      out_bvalid_ff <= out_bvalid_in;
      out_pad_ff    <= out_pad_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = {out_pad_ff, out_bvalid_ff};
   assign rsp_tlast  = out_last_ff;

   a_clear_at_end: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_item.last) |=> (phase_ff == PHASE_FIRST && held_ff == 6'd0 && !stopped_ff))
      else $error("state not cleared at end of message");

   a_no_byte_after_pad: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_bvalid_ff) |-> !out_pad_ff)
      else $error("byte produced after padding");

   a_stopped_holds_phase: assert property (@(posedge clock) disable iff (reset)
      (pop && stopped_ff && !pop_item.last) |=> (stopped_ff && $stable(phase_ff)))
      else $error("state moved while stopped");

   a_first_sextet_no_byte: assert property (@(posedge clock) disable iff (reset)
      (pop && !stopped_ff && phase_ff == PHASE_FIRST) |=> !out_bvalid_ff)
      else $error("byte produced on first sextet");

endmodule

[bench/tb_base64_stream_decoder_unit.sv]
`timescale 1ns / 1ps
// tb_base64_stream_decoder_unit: self-checking bench for the Base64 stream decoder.
// Depends on b64d_pkg and base64_stream_decoder_unit; drives characters in, checks
// every result transaction against a typed-in result or a cycle-free model of the decoder.
module tb_base64_stream_decoder_unit;
   import b64d_pkg::*;

   // Expected contents of one result transaction.
   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       msg_end;
      logic       pad;
   } decoded_type;

   // Per-transaction note handed from the driver to the monitor: a directed row
   // may carry its result typed in, otherwise the model decides.
   typedef struct packed {
      logic        typed;
      decoded_type want;
   } stage_type;

   typedef struct packed {
      logic [7:0]  ch;
      logic        last;
      logic        typed;
      decoded_type want;
   } stim_row_type;

   localparam decoded_type QUIET   = '{8'h00, 1'b0, 1'b0, 1'b0};
   localparam decoded_type PADDED  = '{8'h00, 1'b0, 1'b0, 1'b1};
   localparam decoded_type PAD_END = '{8'h00, 1'b0, 1'b1, 1'b1};
   localparam int          DIRECTED_ROWS = 25;
   localparam int          RANDOM_WEIGHT = 1950;

   // Directed table: extremes, invalid bytes, early and late padding, stopped
   // state, end-of-message clear and a group cut short by the end mark.
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{8'h41, 1'b0, 1'b1, QUIET},    // 'A' first sextet only loads the holder
      '{8'h00, 1'b0, 1'b1, QUIET},    // invalid, skipped
      '{8'hFF, 1'b0, 1'b1, QUIET},    // top byte, skipped
      '{8'h80, 1'b0, 1'b1, QUIET},    // 128 and above are outside the alphabet
      '{8'h3D, 1'b0, 1'b1, QUIET},    // '=' in position two is skipped
      '{8'h2F, 1'b0, 1'b0, QUIET},    // '/' sextet 63
      '{8'h2B, 1'b0, 1'b0, QUIET},    // '+' sextet 62
      '{8'h7A, 1'b0, 1'b0, QUIET},    // 'z'
      '{8'h39, 1'b0, 1'b0, QUIET},    // '9'
      '{8'h61, 1'b0, 1'b0, QUIET},    // 'a'
      '{8'h3D, 1'b0, 1'b1, PADDED},   // '=' in position three stops decoding
      '{8'h51, 1'b0, 1'b1, PADDED},   // ignored while stopped
      '{8'h3D, 1'b1, 1'b1, PAD_END},  // end clears the stop
      '{8'h3D, 1'b0, 1'b1, QUIET},    // '=' in position one is skipped
      '{8'h54, 1'b0, 1'b0, QUIET},    // "TWFu" decodes to "Man"
      '{8'h57, 1'b0, 1'b0, QUIET},
      '{8'h46, 1'b0, 1'b0, QUIET},
      '{8'h75, 1'b1, 1'b0, QUIET},
      '{8'h54, 1'b0, 1'b0, QUIET},    // "TWE=" pads in position four
      '{8'h57, 1'b0, 1'b0, QUIET},
      '{8'h45, 1'b0, 1'b0, QUIET},
      '{8'h3D, 1'b1, 1'b1, PAD_END},
      '{8'h5A, 1'b0, 1'b0, QUIET},    // "Zm9" ends mid-group, leftover dropped
      '{8'h6D, 1'b0, 1'b0, QUIET},
      '{8'h39, 1'b1, 1'b0, QUIET}
   };

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] char_in
   logic       req_tlast  = 1'b0;    // last_char
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] data_byte
   logic [1:0] rsp_tuser;            // [0] byte_valid, [1] pad_seen
   logic       rsp_tlast;            // message_end

   // Model state: next position in the group, previous sextet, padding stop.
   logic [1:0] dec_phase   = PHASE_FIRST;
   logic [5:0] dec_held    = 6'd0;
   logic       dec_stopped = 1'b0;

   decoded_type expected_bytes [$];   // results owed by the decoder, oldest first
   stage_type   staged_chars   [$];   // notes for characters offered but not yet taken
   logic [7:0]  msg_bytes      [$];   // message being built by the generator
   logic        steady        = 1'b0; // suppress idling on both sides
   int          error_count   = 0;
   int          results_seen  = 0;
   int          chars_taken   = 0;
   int          messages_seen = 0;
   decoded_type owed;
   decoded_type modelled;
   stage_type   note;

   base64_stream_decoder_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Hold reset at the start, then release it for good.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #5_000_000;
      $display("%0t ns timeout: decoder stopped making progress", $time);
      $display("TEST FAILED");
      $finish;
   end

   // Map a character to {hit, sextet}; hit is low outside the alphabet.
   function automatic logic [6:0] lookup_sextet(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= "A" && c <= "Z") begin
         v = c - "A";
      end else if (c >= "a" && c <= "z") begin
         v = c - "a" + 8'd26;
      end else if (c >= "0" && c <= "9") begin
         v = c - "0" + 8'd52;
      end else if (c == "+") begin
         v = 8'd62;
      end else if (c == "/") begin
         v = 8'd63;
      end else begin
         return 7'd0;
      end
      return {1'b1, v[5:0]};
   endfunction

   function automatic logic [7:0] encode_sextet(input logic [5:0] s);
      if (s < 6'd26) return 8'h41 + {2'b00, s};
      if (s < 6'd52) return 8'h61 + {2'b00, s} - 8'd26;
      if (s < 6'd62) return 8'h30 + {2'b00, s} - 8'd52;
      if (s == 6'd62) return 8'h2B;
      return 8'h2F;
   endfunction

   // Advance the model by one character and return the result it owes.
   function automatic decoded_type decode_char(input logic [7:0] c, input logic last);
      decoded_type r;
      logic [6:0]  look;
      r    = QUIET;
      look = lookup_sextet(c);
      if (!dec_stopped) begin
         if (c == PAD_CHAR && dec_phase >= PHASE_THIRD) begin
            dec_stopped = 1'b1;
         end else if (look[6]) begin
            case (dec_phase)
               PHASE_FIRST:  r.data = 8'h00;
               PHASE_SECOND: r.data = {dec_held, look[5:4]};
               PHASE_THIRD:  r.data = {dec_held[3:0], look[5:2]};
               default:      r.data = {dec_held[1:0], look[5:0]};
            endcase
            r.valid   = (dec_phase != PHASE_FIRST);
            dec_held  = look[5:0];
            dec_phase = dec_phase + 2'd1;
         end
      end
      r.msg_end = last;
      r.pad     = dec_stopped;
      // end of message: forget any partial group and the stop
      if (last) begin
         dec_phase   = PHASE_FIRST;
         dec_held    = 6'd0;
         dec_stopped = 1'b0;
      end
      return r;
   endfunction

   task automatic compare_field(input string what, input int want, input int seen);
      if (want != seen) begin
         error_count++;
         $display("%0t ns mismatch on %s: expected 0x%0h, actual 0x%0h",
                  $time, what, want, seen);
      end
   endtask

   // Monitor: check the result transaction first, then record the character
   // taken at the same edge, so the queue order never depends on scheduling.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (rsp_tlast) messages_seen++;
            if (expected_bytes.size() == 0) begin
               error_count++;
               $display("%0t ns unexpected result: expected none, actual data 0x%0h",
                        $time, rsp_tdata);
            end else begin
               owed = expected_bytes.pop_front();
               compare_field("data_byte",   owed.data,    rsp_tdata);
               compare_field("byte_valid",  owed.valid,   rsp_tuser[0]);
               compare_field("pad_seen",    owed.pad,     rsp_tuser[1]);
               compare_field("message_end", owed.msg_end, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) begin
            chars_taken++;
            note     = staged_chars.pop_front();
            modelled = decode_char(req_tdata, req_tlast);
            expected_bytes.push_back(note.typed ? note.want : modelled);
         end
      end
   end

   // Receiver: stall about a fifth of the cycles, never during the steady stretch.
   always @(posedge clock) begin
      rsp_tready <= !reset && (steady || $urandom_range(99) >= 22);
   end

   // Offer one character and hold it until the decoder takes it.
   task automatic send_char(input logic [7:0] c, input logic last, input logic typed,
                            input decoded_type want);
      if (!steady && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      staged_chars.push_back(stage_type'{typed, want});
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Pause the sender until every owed result has been collected.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0 || staged_chars.size() != 0) @(posedge clock);
   endtask

   // Build one message: mostly proper Base64 with padding and light noise,
   // otherwise loose alphabet soup or raw bytes.
   task automatic build_message();
      int          kind;
      int          n;
      int          pick;
      logic [23:0] w;
      logic [7:0]  grp [4];
      msg_bytes.delete();
      kind = $urandom_range(99);
      if (kind < 60) begin
         n = $urandom_range(0, 12);
         for (int i = 0; i < n; i += 3) begin
            w      = 24'($urandom());
            grp[0] = encode_sextet(w[23:18]);
            grp[1] = encode_sextet(w[17:12]);
            grp[2] = (n - i > 1) ? encode_sextet(w[11:6]) : PAD_CHAR;
            grp[3] = (n - i > 2) ? encode_sextet(w[5:0])  : PAD_CHAR;
            for (int k = 0; k < 4; k++) begin
               if ($urandom_range(99) < 8) msg_bytes.push_back(8'($urandom_range(255)));
               msg_bytes.push_back(grp[k]);
            end
         end
         // trailing junk after the padding
         if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 3))
               msg_bytes.push_back(encode_sextet(6'($urandom_range(63))));
         end
      end else if (kind < 85) begin
         n = $urandom_range(1, 20);
         repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 12)      msg_bytes.push_back(PAD_CHAR);
            else if (pick < 22) msg_bytes.push_back(8'($urandom_range(255)));
            else                msg_bytes.push_back(encode_sextet(6'($urandom_range(63))));
         end
      end else begin
         n = $urandom_range(1, 16);
         repeat (n) msg_bytes.push_back(8'($urandom_range(255)));
      end
      if (msg_bytes.size() == 0) msg_bytes.push_back(encode_sextet(6'($urandom_range(63))));
   endtask

   // Sender: directed table, a full drain, then random messages.
   initial begin
      int         weight;
      logic       paused;
      logic       is_last;
      weight = 0;
      paused = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_char(DIRECTED[i].ch, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].want);
      drain_results();

      while (weight < RANDOM_WEIGHT) begin
         build_message();
         steady <= (weight >= 600 && weight < 900);
         foreach (msg_bytes[k]) begin
            is_last = (k == msg_bytes.size() - 1);
            send_char(msg_bytes[k], is_last, 1'b0, QUIET);
            // count every character offered
            weight++;
         end
         if (!paused && weight >= 1000) begin
            drain_results();
            paused = 1'b1;
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("Decoded %0d characters over %0d messages, %0d results checked,",
               chars_taken, messages_seen, results_seen);
      $display("with padding, invalid bytes and random stalls on both channels.");
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
